>>> sv/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants for the bounded set table
// Opcodes, transaction payload structs, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Default table sizing, handed to the top level as parameter defaults.
  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields.
  localparam int IN_VALUE_W  = 32;
  localparam int COUNT_OUT_W = 6;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // Request transaction.
  typedef struct packed {
    opcode_t                 opcode;
    logic [IN_VALUE_W-1:0]   entry_value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic                    success;
    logic [COUNT_OUT_W-1:0]  match_count;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic                    is_empty;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE,
    ST_DONE
  } seq_state_t;

endpackage

>>> sv/bst_store.sv
// ----------------------------------------------------------------------------
// bst_store: entry memory of the bounded set table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_store #(
  parameter int CAPACITY    = bst_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic [AW-1:0]          rd_addr,
  output logic [VALUE_WIDTH-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [VALUE_WIDTH-1:0] wr_data
);

  logic [VALUE_WIDTH-1:0] mem_r [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, data available the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/bst_seq.sv
// ----------------------------------------------------------------------------
// bst_seq: sequencer and shared comparator of the bounded set table
// Scans the held entries one per cycle through a single equality compare,
// then applies the add, remove, lookup or clear update and posts the result.
// ----------------------------------------------------------------------------
module bst_seq #(
  parameter int CAPACITY    = bst_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bst_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bst_pkg::out_item_t     out_data,
  output logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [VALUE_WIDTH-1:0] wr_data
);

  bst_pkg::seq_state_t    state_r, state_nxt;
  bst_pkg::opcode_t       opcode_r, opcode_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [CW-1:0]          held_r, held_nxt;
  logic [CW-1:0]          issue_r, issue_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]          matches_r, matches_nxt;
  logic                   found_r, found_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic                   ok_r, ok_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bst_pkg::out_item_t     out_data_r, out_data_nxt;

  logic                   scan_done;
  logic                   hit;
  logic                   out_free;
  logic                   add_ok;
  logic [CW-1:0]          held_dec;
  logic [VALUE_WIDTH+bst_pkg::IN_VALUE_W-1:0] value_wide;
  logic [CW+bst_pkg::COUNT_OUT_W-1:0]         matches_wide;
  logic [CW+bst_pkg::COUNT_OUT_W-1:0]         held_wide;

  // Shared compare and status terms.
  assign scan_done    = (issue_r == held_r) && !cmp_vld_r;
  assign hit          = cmp_vld_r && (rd_data == value_r);
  assign out_free     = !out_valid_r || !out_stall;
  assign add_ok       = (held_r < CW'(CAPACITY)) && (matches_r == '0);
  assign held_dec     = held_r - 1'b1;
  assign value_wide   = {{VALUE_WIDTH{1'b0}}, in_data.entry_value};
  assign matches_wide = {{bst_pkg::COUNT_OUT_W{1'b0}}, matches_r};
  assign held_wide    = {{bst_pkg::COUNT_OUT_W{1'b0}}, held_r};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.opcode == bst_pkg::OP_CLEAR) ? bst_pkg::ST_DONE
                                                            : bst_pkg::ST_SCAN;
        end
      end
      bst_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = bst_pkg::ST_DECIDE;
        end
      end
      bst_pkg::ST_DECIDE: begin
        if ((opcode_r == bst_pkg::OP_REMOVE) && found_r) begin
          state_nxt = bst_pkg::ST_MOVE;
        end else begin
          state_nxt = bst_pkg::ST_DONE;
        end
      end
      bst_pkg::ST_MOVE: begin
        state_nxt = bst_pkg::ST_DONE;
      end
      bst_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bst_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_stall = (state_r != bst_pkg::ST_IDLE);
    rd_addr  = issue_r[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = held_r[AW-1:0];
    wr_data  = value_r;
    case (state_r)
      bst_pkg::ST_DECIDE: begin
        // Fetch the last entry in case a remove has to move it.
        rd_addr = held_dec[AW-1:0];
        if ((opcode_r == bst_pkg::OP_ADD) && add_ok) begin
          wr_en = 1'b1;
        end
      end
      bst_pkg::ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    opcode_nxt    = opcode_r;
    value_nxt     = value_r;
    held_nxt      = held_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    matches_nxt   = matches_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      bst_pkg::ST_IDLE: begin
        if (in_valid) begin
          opcode_nxt  = in_data.opcode;
          value_nxt   = value_wide[VALUE_WIDTH-1:0];
          issue_nxt   = '0;
          cmp_vld_nxt = 1'b0;
          matches_nxt = '0;
          found_nxt   = 1'b0;
          ok_nxt      = 1'b0;
          if (in_data.opcode == bst_pkg::OP_CLEAR) begin
            held_nxt = '0;
            ok_nxt   = 1'b1;
          end
        end
      end
      bst_pkg::ST_SCAN: begin
        // Issue the next read while comparing the previous one.
        if (issue_r != held_r) begin
          issue_nxt   = issue_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[AW-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (hit) begin
          matches_nxt = matches_r + 1'b1;
          if (!found_r) begin
            found_nxt = 1'b1;
            slot_nxt  = cmp_idx_r;
          end
        end
      end
      bst_pkg::ST_DECIDE: begin
        case (opcode_r)
          bst_pkg::OP_ADD: begin
            if (add_ok) begin
              held_nxt = held_r + 1'b1;
              ok_nxt   = 1'b1;
            end
          end
          bst_pkg::OP_REMOVE: begin
            if (found_r) begin
              held_nxt = held_dec;
            end
          end
          bst_pkg::OP_LOOKUP: begin
            ok_nxt = (matches_r != '0);
          end
          default: begin
          end
        endcase
      end
      bst_pkg::ST_MOVE: begin
        ok_nxt = 1'b1;
      end
      bst_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.success     = ok_r;
          out_data_nxt.match_count = matches_wide[bst_pkg::COUNT_OUT_W-1:0];
          out_data_nxt.entry_count = held_wide[bst_pkg::COUNT_OUT_W-1:0];
          out_data_nxt.is_empty    = (held_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bst_pkg::ST_IDLE;
      held_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    opcode_r   <= opcode_nxt;
    value_r    <= value_nxt;
    issue_r    <= issue_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    matches_r  <= matches_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/bounded_set_table.sv
// ----------------------------------------------------------------------------
// bounded_set_table: fixed-capacity table of distinct values
// Add, remove, lookup and clear requests over a linear-search entry memory.
//
//   Channel  Direction  Handshake           Payload
//   in_      request    in_valid/in_stall   bst_pkg::in_item_t
//   out_     result     out_valid/out_stall bst_pkg::out_item_t
//
// An add, a lookup or a remove scans the held entries and then decides; a
// remove that finds its value also moves the last entry into the freed slot,
// and a clear skips the scan. One entry is read and compared per cycle, and
// the next request is taken in the cycle after the result is loaded. Reset
// empties the table at once.
// A result waits in the output register while the next request runs; the
// sequencer holds only when a second result is ready first.
// ----------------------------------------------------------------------------
module bounded_set_table #(
  parameter int CAPACITY    = bst_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bst_pkg::out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Sequencer with the shared comparator.
  bst_seq #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Entry memory.
  bst_store #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

>>> sv/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker: port-level checks for the bounded set table
// Watches both channels and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module bst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bst_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bst_pkg::out_item_t out_data
);

  // A stalled result transaction stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("bst: stalled result changed or dropped");

  // The empty flag agrees with the entry count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
    else $error("bst: empty flag disagrees with entry count");

  // Stored values are distinct, so at most one entry can match.
  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.match_count <= 6'd1))
    else $error("bst: more than one matching entry");

  // An accepted request leaves the sequencer busy, stalling further requests.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("bst: request accepted on consecutive cycles");

endmodule

bind bounded_set_table bst_checker u_bst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
